### design/serial_hid_frame_receiver_top_defines.svh
// Assertion macros for the serial HID frame receiver.
// Included by the top level; assumes signals named clk and rst_n in scope.
`ifndef SERIAL_HID_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SERIAL_HID_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/shfr_pkg.sv
// Shared types and constants of the serial HID frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package shfr_pkg;

  // Frame store size and register defaults.
  localparam int MAX_FRAME_BYTES_DEF = 8;
  localparam logic [12:0] EXPECTED_LENGTH_RST = 13'd8;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;

  // Result kinds.
  localparam logic [2:0] KIND_DATA = 3'd0;
  localparam logic [2:0] KIND_ACK = 3'd1;
  localparam logic [2:0] KIND_NACK = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd3;
  localparam logic [2:0] KIND_SYNC = 3'd4;
  localparam logic [2:0] KIND_FAIL = 3'd5;

  // Line tokens and type byte fields.
  localparam logic [7:0] TOK_SYNC = 8'h16;
  localparam logic [7:0] TOK_ACK = 8'h06;
  localparam logic [7:0] TOK_NACK = 8'h15;
  localparam int TYPE_FINAL_BIT = 7;
  localparam logic [6:0] TYPE_NOTIFY = 7'h05;
  localparam logic [12:0] COUNT_MAX = 13'h1FFF;
  localparam logic [3:0] RETRY_MAX = 4'hF;

  // Command queue depth.
  localparam int QUEUE_DEPTH = 2;

  // Receive phase of the front end.
  typedef enum logic [1:0] {
    FP_TYPE,
    FP_LEN,
    FP_DATA,
    FP_CHECK
  } fph_t;

  // Token that follows the released data bytes.
  typedef enum logic [1:0] {
    MID_NONE,
    MID_ACK,
    MID_NACK,
    MID_SYNC
  } mid_t;

  // Closing result of a command.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DONE,
    TAIL_FAIL
  } tail_t;

  // Step of the back end while it plays out a command.
  typedef enum logic [1:0] {
    BS_DATA,
    BS_MID,
    BS_TAIL,
    BS_END
  } bstep_t;

  // One command: all results that a single received byte causes.
  typedef struct packed {
    logic [3:0] n_data;
    mid_t mid;
    tail_t tail;
    logic [12:0] msg_bytes;
  } cmd_t;

endpackage

`default_nettype wire

### design/serial_hid_frame_receiver_top.sv
// Serial HID frame receiver: byte deframer with ACK/NACK and data release.
// Usage:
//   Input channel in_valid/in_stall/in_rx_byte carries one received byte per
//   request. Output channel out_valid/out_stall carries one result per request
//   (kind, value, message_bytes, last); last marks the final result of a byte.
//   cfg_we/cfg_index/cfg_wdata write expected_length (index 0) and
//   retry_limit (index 1); write them only while the block is idle.
// Timing:
//   Bytes are taken one per cycle while no command is draining. A byte that
//   causes results goes through the command queue, the back-end command register and
//   the output register; a checksum byte releasing N data bytes produces N+1 or N+2
//   results, one per cycle while out_stall is low, after the back end loads the command.
//   A byte in the data phase of a frame is held off until the back end has
//   drained every queued command, since it reads the frame store; other bytes
//   are held off only while the two-entry command queue is full.
// Reset and stall:
//   Reset (synchronous) empties the queue and output register and restores
//   budget 8 and retry limit 3. A high out_stall holds the output register and
//   pauses the back end; bytes outside the data phase still enter until the queue fills.
`default_nettype none

module serial_hid_frame_receiver_top #(
  parameter int MAX_FRAME_BYTES = shfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_value,
  output logic [12:0] out_message_bytes,
  output logic out_last,
  input  wire logic cfg_we,
  input  wire logic [shfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [shfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import shfr_pkg::*;

`include "serial_hid_frame_receiver_top_defines.svh"

  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  logic q_full;
  cmd_t q_cmd;
  logic back_busy;
  logic drain_busy;
  logic store_wr;
  logic [MAX_FRAME_BYTES-1:0][7:0] store;

  assign drain_busy = back_busy || q_valid;

  // Front end: framing and state.
  shfr_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_full(q_full),
    .drain_busy(drain_busy),
    .push(push),
    .push_cmd(push_cmd),
    .store(store),
    .store_wr(store_wr)
  );

  // Command queue.
  shfr_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_cmd(push_cmd),
    .pop(pop),
    .q_valid(q_valid),
    .q_full(q_full),
    .q_cmd(q_cmd)
  );

  // Back end: result playout.
  shfr_back #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_cmd(q_cmd),
    .pop(pop),
    .store(store),
    .busy(back_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_value(out_value),
    .out_message_bytes(out_message_bytes),
    .out_last(out_last)
  );

  // The queue never takes a command while it is full.
  `SHFR_ASSERT_IMPL(a_no_overflow, push, !q_full, "command pushed into a full queue")

  // The frame store is never written while a command may still read it.
  `SHFR_ASSERT_IMPL(a_store_free, store_wr, !drain_busy, "frame store written during drain")

  // Done and failure always close the results of a byte.
  `SHFR_ASSERT_IMPL(a_end_is_last,
    out_valid && ((out_kind == KIND_DONE) || (out_kind == KIND_FAIL)), out_last,
    "done or failure result not marked last")

  // A popped command is always played out by the back end.
  `SHFR_ASSERT_NEXT(a_pop_busy, pop, back_busy, "back end idle after taking a command")

endmodule

`default_nettype wire

### design/shfr_front.sv
// Front end: accepts received bytes, runs the framing state machine,
// fills the frame store and pushes commands. Depends on shfr_pkg.
`default_nettype none

module shfr_front #(
  parameter int MAX_FRAME_BYTES = shfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic cfg_we,
  input  wire logic [shfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [shfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic q_full,
  input  wire logic drain_busy,
  output logic push,
  output shfr_pkg::cmd_t push_cmd,
  output logic [MAX_FRAME_BYTES-1:0][7:0] store,
  output logic store_wr
);
  import shfr_pkg::*;

  localparam int IDX_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam logic [3:0] MAX_LEN = 4'(MAX_FRAME_BYTES);

  fph_t phase_r, phase_nxt;
  logic [7:0] frame_type_r, frame_type_nxt;
  logic [3:0] frame_length_r, frame_length_nxt;
  logic [3:0] bytes_in_frame_r, bytes_in_frame_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [3:0] retry_count_r, retry_count_nxt;
  logic [12:0] message_count_r, message_count_nxt;
  logic [12:0] budget_left_r, budget_left_nxt;
  logic [12:0] expected_length_r, expected_length_nxt;
  logic [3:0] retry_limit_r, retry_limit_nxt;
  logic [MAX_FRAME_BYTES-1:0][7:0] store_r;

  logic accept;
  logic new_msg;
  logic [13:0] count_sum;
  logic [12:0] count_sat;
  logic [12:0] budget_sub;
  logic [3:0] retry_inc;
  logic [3:0] next_bytes;

  // Data bytes wait while the back end may still read the store.
  assign in_stall = q_full || ((phase_r == FP_DATA) && drain_busy);
  assign accept = in_valid && !in_stall;
  assign store = store_r;
  assign store_wr = accept && (phase_r == FP_DATA) && (bytes_in_frame_r < MAX_LEN);

  // Arithmetic used at the checksum byte.
  assign count_sum = {1'b0, message_count_r} + {10'd0, frame_length_r};
  assign count_sat = count_sum[13] ? COUNT_MAX : count_sum[12:0];
  assign budget_sub = (budget_left_r > {9'd0, frame_length_r}) ?
                      budget_left_r - {9'd0, frame_length_r} : 13'd0;
  assign retry_inc = (retry_count_r < RETRY_MAX) ? retry_count_r + 4'd1 : retry_count_r;
  assign next_bytes = bytes_in_frame_r + 4'd1;

  // Framing state machine: next state and command to push.
  always_comb begin
    phase_nxt = phase_r;
    frame_type_nxt = frame_type_r;
    frame_length_nxt = frame_length_r;
    bytes_in_frame_nxt = bytes_in_frame_r;
    running_xor_nxt = running_xor_r;
    retry_count_nxt = retry_count_r;
    message_count_nxt = message_count_r;
    budget_left_nxt = budget_left_r;
    expected_length_nxt = expected_length_r;
    retry_limit_nxt = retry_limit_r;
    push = 1'b0;
    push_cmd = '{n_data: 4'd0, mid: MID_NONE, tail: TAIL_NONE, msg_bytes: 13'd0};
    new_msg = 1'b0;

    if (accept) begin
      case (phase_r)
        FP_TYPE: begin
          if ((budget_left_r == 13'd0) || (retry_count_r >= retry_limit_r)) begin
            push = 1'b1;
            push_cmd.tail = TAIL_FAIL;
            new_msg = 1'b1;
          end else if (in_rx_byte == TOK_SYNC) begin
            push = 1'b1;
            push_cmd.mid = MID_SYNC;
            new_msg = 1'b1;
          end else begin
            frame_type_nxt = in_rx_byte;
            running_xor_nxt = 8'd0;
            bytes_in_frame_nxt = 4'd0;
            phase_nxt = FP_LEN;
          end
        end
        FP_LEN: begin
          if ((in_rx_byte[7:4] != in_rx_byte[3:0]) || (in_rx_byte[3:0] > MAX_LEN)) begin
            push = 1'b1;
            push_cmd.tail = TAIL_FAIL;
            new_msg = 1'b1;
          end else begin
            frame_length_nxt = in_rx_byte[3:0];
            phase_nxt = (in_rx_byte[3:0] == 4'd0) ? FP_CHECK : FP_DATA;
          end
        end
        FP_DATA: begin
          running_xor_nxt = running_xor_r ^ in_rx_byte;
          bytes_in_frame_nxt = next_bytes;
          if (next_bytes >= frame_length_r) begin
            phase_nxt = FP_CHECK;
          end
        end
        FP_CHECK: begin
          phase_nxt = FP_TYPE;
          push = 1'b1;
          if (in_rx_byte == running_xor_r) begin
            retry_count_nxt = 4'd0;
            push_cmd.mid = MID_ACK;
            // Notification frames are acknowledged and their data dropped.
            if (frame_type_r[6:0] != TYPE_NOTIFY) begin
              push_cmd.n_data = frame_length_r;
              message_count_nxt = count_sat;
              budget_left_nxt = budget_sub;
              if (frame_type_r[TYPE_FINAL_BIT]) begin
                push_cmd.tail = TAIL_DONE;
                push_cmd.msg_bytes = count_sat;
                new_msg = 1'b1;
              end else if (budget_sub == 13'd0) begin
                push_cmd.tail = TAIL_FAIL;
                new_msg = 1'b1;
              end
            end
          end else begin
            push_cmd.mid = MID_NACK;
            retry_count_nxt = retry_inc;
            if (retry_inc >= retry_limit_r) begin
              push_cmd.tail = TAIL_FAIL;
              new_msg = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = FP_TYPE;
        end
      endcase
    end

    // A new message clears the retry and byte counts and reloads the budget.
    if (new_msg) begin
      phase_nxt = FP_TYPE;
      retry_count_nxt = 4'd0;
      message_count_nxt = 13'd0;
      budget_left_nxt = expected_length_r;
    end

    // Register writes; the budget reloads at once between messages.
    if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_LENGTH: begin
          expected_length_nxt = cfg_wdata;
          if ((phase_r == FP_TYPE) && (message_count_r == 13'd0)) begin
            budget_left_nxt = cfg_wdata;
          end
        end
        REG_RETRY_LIMIT: begin
          retry_limit_nxt = cfg_wdata[3:0];
        end
        default: begin
          retry_limit_nxt = retry_limit_r;
        end
      endcase
    end
  end

  // Control and counter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= FP_TYPE;
      frame_type_r <= 8'd0;
      frame_length_r <= 4'd0;
      bytes_in_frame_r <= 4'd0;
      running_xor_r <= 8'd0;
      retry_count_r <= 4'd0;
      message_count_r <= 13'd0;
      budget_left_r <= EXPECTED_LENGTH_RST;
      expected_length_r <= EXPECTED_LENGTH_RST;
      retry_limit_r <= RETRY_LIMIT_RST;
    end else begin
      phase_r <= phase_nxt;
      frame_type_r <= frame_type_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_in_frame_r <= bytes_in_frame_nxt;
      running_xor_r <= running_xor_nxt;
      retry_count_r <= retry_count_nxt;
      message_count_r <= message_count_nxt;
      budget_left_r <= budget_left_nxt;
      expected_length_r <= expected_length_nxt;
      retry_limit_r <= retry_limit_nxt;
    end
  end

  // Frame store: payload only, written at the current byte position.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[bytes_in_frame_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

### design/shfr_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on shfr_pkg for the command type.
`default_nettype none

module shfr_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire shfr_pkg::cmd_t push_cmd,
  input  wire logic pop,
  output logic q_valid,
  output logic q_full,
  output shfr_pkg::cmd_t q_cmd
);
  import shfr_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t ent0_r, ent0_nxt;
  cmd_t ent1_r, ent1_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full = (count_r == CNT_FULL);
  assign q_cmd = ent0_r;

  // Head always sits in entry 0; a pop shifts the second entry forward.
  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    count_nxt = count_r;
    case ({push, pop})
      2'b10: begin
        if (count_r == '0) begin
          ent0_nxt = push_cmd;
        end else begin
          ent1_nxt = push_cmd;
        end
        count_nxt = count_r + CNT_ONE;
      end
      2'b01: begin
        ent0_nxt = ent1_r;
        count_nxt = count_r - CNT_ONE;
      end
      2'b11: begin
        if (count_r == CNT_ONE) begin
          ent0_nxt = push_cmd;
        end else begin
          ent0_nxt = ent1_r;
          ent1_nxt = push_cmd;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entries are payload.
  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

endmodule

`default_nettype wire

### design/shfr_back.sv
// Back end: pops commands and plays out their results one per cycle, while
// out_stall does not hold it, into the output register. Depends on shfr_pkg.
`default_nettype none

module shfr_back #(
  parameter int MAX_FRAME_BYTES = shfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire shfr_pkg::cmd_t q_cmd,
  output logic pop,
  input  wire logic [MAX_FRAME_BYTES-1:0][7:0] store,
  output logic busy,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_value,
  output logic [12:0] out_message_bytes,
  output logic out_last
);
  import shfr_pkg::*;

  localparam int IDX_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

  logic busy_r, busy_nxt;
  bstep_t step_r, step_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [7:0] value_r, value_nxt;
  logic [12:0] msg_r, msg_nxt;
  logic last_r, last_nxt;
  logic adv;
  bstep_t follow;

  // Step that comes once the data bytes of a command are out.
  function automatic bstep_t after_data(input cmd_t c);
    bstep_t s;
    if (c.mid != MID_NONE) begin
      s = BS_MID;
    end else if (c.tail != TAIL_NONE) begin
      s = BS_TAIL;
    end else begin
      s = BS_END;
    end
    return s;
  endfunction

  // Step that comes after the token.
  function automatic bstep_t after_mid(input cmd_t c);
    bstep_t s;
    s = (c.tail != TAIL_NONE) ? BS_TAIL : BS_END;
    return s;
  endfunction

  assign adv = !out_valid_r || !out_stall;
  assign busy = busy_r;
  assign out_valid = out_valid_r;
  assign out_kind = kind_r;
  assign out_value = value_r;
  assign out_message_bytes = msg_r;
  assign out_last = last_r;

  // Sequencer: load a command, then emit one result per free output slot.
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    cmd_nxt = cmd_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt = kind_r;
    value_nxt = value_r;
    msg_nxt = msg_r;
    last_nxt = last_r;
    pop = 1'b0;
    follow = BS_END;

    if (!busy_r) begin
      if (q_valid) begin
        pop = 1'b1;
        busy_nxt = 1'b1;
        cmd_nxt = q_cmd;
        idx_nxt = 4'd0;
        step_nxt = (q_cmd.n_data != 4'd0) ? BS_DATA : after_data(q_cmd);
      end
    end else if (adv) begin
      out_valid_nxt = 1'b1;
      msg_nxt = 13'd0;
      value_nxt = 8'd0;
      case (step_r)
        BS_DATA: begin
          kind_nxt = KIND_DATA;
          value_nxt = store[idx_r[IDX_W-1:0]];
          idx_nxt = idx_r + 4'd1;
          follow = ((idx_r + 4'd1) < cmd_r.n_data) ? BS_DATA : after_data(cmd_r);
        end
        BS_MID: begin
          case (cmd_r.mid)
            MID_ACK: begin
              kind_nxt = KIND_ACK;
              value_nxt = TOK_ACK;
            end
            MID_NACK: begin
              kind_nxt = KIND_NACK;
              value_nxt = TOK_NACK;
            end
            default: begin
              kind_nxt = KIND_SYNC;
              value_nxt = TOK_SYNC;
            end
          endcase
          follow = after_mid(cmd_r);
        end
        default: begin
          if (cmd_r.tail == TAIL_DONE) begin
            kind_nxt = KIND_DONE;
            msg_nxt = cmd_r.msg_bytes;
          end else begin
            kind_nxt = KIND_FAIL;
          end
          follow = BS_END;
        end
      endcase
      // The last result of a command is the last one of its input byte.
      last_nxt = (follow == BS_END);
      step_nxt = follow;
      busy_nxt = (follow != BS_END);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= BS_END;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and output payload.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    kind_r <= kind_nxt;
    value_r <= value_nxt;
    msg_r <= msg_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire
